>>> rtl/szc_pkg.sv
// ----------------------------------------------------------------------------
// szc_pkg: shared types and constants of the stream zip combiner
// Sizes, field widths, item and result codes, and the command record that
// passes from the front end to the back end.
// ----------------------------------------------------------------------------
package szc_pkg;

    // Sizes of the block
    localparam int MAX_SOURCES = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int DATA_WIDTH  = 32;

    // Port field widths
    localparam int KIND_W  = 2;
    localparam int SRC_W   = 2;
    localparam int VALUE_W = 32;
    localparam int CNT_W   = 3;

    // Derived widths
    localparam int PTR_W      = $clog2(QUEUE_DEPTH);
    localparam int FILL_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W     = $clog2(MAX_SOURCES * QUEUE_DEPTH);
    localparam int LANE_CNT_W = $clog2(MAX_SOURCES + 1);

    // Command queue between front and back
    localparam int CMDQ_DEPTH = 2;
    localparam int QPTR_W     = $clog2(CMDQ_DEPTH);
    localparam int PEND_W     = $clog2(CMDQ_DEPTH + 1);

    // Input item kinds
    localparam logic [KIND_W-1:0] KIND_VALUE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_COMPLETE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] RES_ZIP      = 2'd0;
    localparam logic [KIND_W-1:0] RES_COMPLETE = 2'd1;
    localparam logic [KIND_W-1:0] RES_ERROR    = 2'd2;
    localparam logic [KIND_W-1:0] RES_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        CMD_ZIP,
        CMD_COMPLETE,
        CMD_ERROR,
        CMD_OVERFLOW
    } cmd_op_t;

    // One unit of work for the back end
    typedef struct packed {
        cmd_op_t                             op;
        logic [SRC_W-1:0]                    src;
        logic [DATA_WIDTH-1:0]               data;
        logic [LANE_CNT_W-1:0]               lanes;
        logic [MAX_SOURCES-1:0][PTR_W-1:0]   heads;
        logic                                done;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic                  en;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_WIDTH-1:0] data;
    } ram_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } ram_rd_t;

endpackage

>>> rtl/szc_ram.sv
// ----------------------------------------------------------------------------
// szc_ram: generic simple dual-port RAM
// One write port, one read port, read data registered on read enable.
// ----------------------------------------------------------------------------
module szc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/szc_front.sv
// ----------------------------------------------------------------------------
// szc_front: input classifier of the stream zip combiner
// Accepts input beats, keeps FIFO pointers, fill counts and completion flags,
// writes values to the store and issues commands to the back end.
// ----------------------------------------------------------------------------
module szc_front import szc_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [KIND_W-1:0] kind,
    input  logic [SRC_W-1:0]  source,
    input  logic [VALUE_W-1:0] value,
    input  logic              cfg_wr_en,
    input  logic [CNT_W-1:0]  cfg_wr_data,
    output ram_wr_t           ram_wr,
    output logic              cmd_push,
    output cmd_t              cmd,
    input  q_status_t         q_status,
    input  logic              zip_done
);

    logic [CNT_W-1:0]  source_count_reg;
    logic [PTR_W-1:0]  rp_reg   [MAX_SOURCES];
    logic [PTR_W-1:0]  rp_next  [MAX_SOURCES];
    logic [FILL_W-1:0] fill_reg [MAX_SOURCES];
    logic [FILL_W-1:0] fill_next[MAX_SOURCES];
    logic [FILL_W-1:0] fill_push[MAX_SOURCES];
    logic [MAX_SOURCES-1:0] completed_reg, completed_next;
    logic              finished_reg, finished_next;
    logic [PEND_W-1:0] pending_reg, pending_next;

    logic [LANE_CNT_W-1:0] active_n;
    logic              src_active;
    logic [FILL_W-1:0] fill_src;
    logic              full_src;
    logic              push_ok;
    logic              hazard;
    logic              accept;
    logic              live;
    logic [PTR_W:0]    pos_sum;
    logic [PTR_W-1:0]  wr_pos;
    logic              all_ready;
    logic              done;

    // Active source count, clamped to the legal range
    always_comb
    begin
        if (source_count_reg == '0)
        begin
            active_n = LANE_CNT_W'(1);
        end
        else if (source_count_reg > CNT_W'(MAX_SOURCES))
        begin
            active_n = LANE_CNT_W'(MAX_SOURCES);
        end
        else
        begin
            active_n = LANE_CNT_W'(source_count_reg);
        end
    end

    assign src_active = LANE_CNT_W'(source) < active_n;
    assign fill_src   = fill_reg[source];
    assign full_src   = fill_src == FILL_W'(QUEUE_DEPTH);
    assign push_ok    = (kind == KIND_VALUE) && !full_src;

    // Hold a value whose slot may still be pending a read by the back end
    assign hazard = push_ok &&
                    ((FILL_W+1)'(fill_src) + (FILL_W+1)'(pending_reg)
                     >= (FILL_W+1)'(QUEUE_DEPTH));

    assign in_stall = q_status.full || hazard;
    assign accept   = in_valid && !in_stall;
    assign live     = accept && !finished_reg && src_active;

    // Tail position of the addressed FIFO
    assign pos_sum = (PTR_W+1)'(rp_reg[source]) + (PTR_W+1)'(fill_src[PTR_W-1:0]);
    assign wr_pos  = (pos_sum >= (PTR_W+1)'(QUEUE_DEPTH))
                   ? PTR_W'(pos_sum - (PTR_W+1)'(QUEUE_DEPTH))
                   : PTR_W'(pos_sum);

    // Fill counts after the push, tuple readiness and completion check
    always_comb
    begin
        all_ready = 1'b1;
        done      = 1'b0;
        for (int j = 0; j < MAX_SOURCES; j++)
        begin
            fill_push[j] = fill_reg[j] + FILL_W'(push_ok && (SRC_W'(j) == source));
            if ((LANE_CNT_W'(j) < active_n) && (fill_push[j] == '0))
            begin
                all_ready = 1'b0;
            end
            if ((LANE_CNT_W'(j) < active_n) && completed_reg[j] &&
                (fill_push[j] == FILL_W'(1)))
            begin
                done = 1'b1;
            end
        end
    end

    // Classify the beat and update the FIFO bookkeeping
    always_comb
    begin
        fill_next      = fill_reg;
        rp_next        = rp_reg;
        completed_next = completed_reg;
        finished_next  = finished_reg;
        cmd_push       = 1'b0;
        cmd            = '0;
        cmd.src        = source;
        ram_wr.en      = 1'b0;
        ram_wr.addr    = ADDR_W'(source) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(wr_pos);
        ram_wr.data    = DATA_WIDTH'(value);
        if (live)
        begin
            unique case (kind)
                KIND_ERROR:
                begin
                    cmd_push      = 1'b1;
                    cmd.op        = CMD_ERROR;
                    finished_next = 1'b1;
                end
                KIND_COMPLETE:
                begin
                    completed_next[source] = 1'b1;
                    if (fill_src == '0)
                    begin
                        cmd_push      = 1'b1;
                        cmd.op        = CMD_COMPLETE;
                        finished_next = 1'b1;
                    end
                end
                KIND_VALUE:
                begin
                    if (full_src)
                    begin
                        cmd_push = 1'b1;
                        cmd.op   = CMD_OVERFLOW;
                        cmd.data = DATA_WIDTH'(value);
                    end
                    else
                    begin
                        ram_wr.en = 1'b1;
                        fill_next = fill_push;
                        if (all_ready)
                        begin
                            cmd_push  = 1'b1;
                            cmd.op    = CMD_ZIP;
                            cmd.lanes = active_n;
                            cmd.done  = done;
                            for (int j = 0; j < MAX_SOURCES; j++)
                            begin
                                cmd.heads[j] = rp_reg[j];
                                if (LANE_CNT_W'(j) < active_n)
                                begin
                                    fill_next[j] = fill_push[j] - FILL_W'(1);
                                    rp_next[j]   = (rp_reg[j] == PTR_W'(QUEUE_DEPTH - 1))
                                                 ? '0 : rp_reg[j] + PTR_W'(1);
                                end
                            end
                            if (done)
                            begin
                                finished_next = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Count zip commands whose reads are not yet finished
    assign pending_next = pending_reg
                        + PEND_W'(cmd_push && (cmd.op == CMD_ZIP))
                        - PEND_W'(zip_done);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_count_reg <= CNT_W'(MAX_SOURCES);
            completed_reg    <= '0;
            finished_reg     <= 1'b0;
            pending_reg      <= '0;
            for (int j = 0; j < MAX_SOURCES; j++)
            begin
                rp_reg[j]   <= '0;
                fill_reg[j] <= '0;
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                source_count_reg <= cfg_wr_data;
            end
            completed_reg <= completed_next;
            finished_reg  <= finished_next;
            pending_reg   <= pending_next;
            rp_reg        <= rp_next;
            fill_reg      <= fill_next;
        end
    end

endmodule

>>> rtl/szc_cmd_queue.sv
// ----------------------------------------------------------------------------
// szc_cmd_queue: command queue between front and back
// Small register FIFO of commands; the head is read in place.
// ----------------------------------------------------------------------------
module szc_cmd_queue import szc_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  cmd_t      cmd_in,
    input  logic      pop,
    output cmd_t      cmd_out,
    output q_status_t q_status
);

    cmd_t              mem_reg [CMDQ_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PEND_W-1:0] count_reg, count_next;

    // Advance pointers with wrap
    assign wr_ptr_next = !push ? wr_ptr_reg
                       : (wr_ptr_reg == QPTR_W'(CMDQ_DEPTH - 1)) ? '0
                       : wr_ptr_reg + QPTR_W'(1);
    assign rd_ptr_next = !pop ? rd_ptr_reg
                       : (rd_ptr_reg == QPTR_W'(CMDQ_DEPTH - 1)) ? '0
                       : rd_ptr_reg + QPTR_W'(1);
    assign count_next  = count_reg + PEND_W'(push) - PEND_W'(pop);

    assign cmd_out        = mem_reg[rd_ptr_reg];
    assign q_status.full  = count_reg == PEND_W'(CMDQ_DEPTH);
    assign q_status.empty = count_reg == '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= cmd_in;
        end
    end

endmodule

>>> rtl/szc_back.sv
// ----------------------------------------------------------------------------
// szc_back: result sequencer of the stream zip combiner
// Takes commands from the queue, reads zipped words from the store one lane
// at a time and drives the output register.
// ----------------------------------------------------------------------------
module szc_back import szc_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    input  q_status_t             q_status,
    output logic                  pop,
    output ram_rd_t               ram_rd,
    input  logic [DATA_WIDTH-1:0] rd_data,
    output logic                  zip_done,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [KIND_W-1:0]     kind_res,
    output logic [SRC_W-1:0]      lane,
    output logic [VALUE_W-1:0]    value_res,
    output logic                  last
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_COMP
    } state_t;

    state_t               state_reg, state_next;
    logic [SRC_W-1:0]     lane_reg, lane_next;
    logic                 out_valid_reg, out_valid_next;
    logic [KIND_W-1:0]    kind_res_reg, kind_res_next;
    logic [SRC_W-1:0]     lane_res_reg, lane_res_next;
    logic [VALUE_W-1:0]   value_res_reg, value_res_next;
    logic                 last_reg, last_next;
    logic                 out_free;
    logic                 is_final;

    assign out_free = !out_valid_reg || !out_stall;
    assign is_final = LANE_CNT_W'(lane_reg) == cmd.lanes - LANE_CNT_W'(1);

    // Sequence results
    always_comb
    begin
        state_next     = state_reg;
        lane_next      = lane_reg;
        out_valid_next = out_valid_reg && out_stall;
        kind_res_next  = kind_res_reg;
        lane_res_next  = lane_res_reg;
        value_res_next = value_res_reg;
        last_next      = last_reg;
        pop            = 1'b0;
        ram_rd.en      = 1'b0;
        ram_rd.addr    = ADDR_W'(lane_reg) * ADDR_W'(QUEUE_DEPTH)
                       + ADDR_W'(cmd.heads[lane_reg]);
        zip_done       = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_status.empty)
                begin
                    if (cmd.op == CMD_ZIP)
                    begin
                        lane_next  = '0;
                        state_next = S_READ;
                    end
                    else if (out_free)
                    begin
                        out_valid_next = 1'b1;
                        last_next      = 1'b1;
                        pop            = 1'b1;
                        lane_res_next  = cmd.src;
                        value_res_next = '0;
                        case (cmd.op)
                            CMD_COMPLETE:
                            begin
                                kind_res_next = RES_COMPLETE;
                                lane_res_next = '0;
                            end
                            CMD_ERROR:
                            begin
                                kind_res_next = RES_ERROR;
                            end
                            default:
                            begin
                                kind_res_next  = RES_OVERFLOW;
                                value_res_next = VALUE_W'(cmd.data);
                            end
                        endcase
                    end
                end
            end
            S_READ:
            begin
                ram_rd.en  = 1'b1;
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_res_next  = RES_ZIP;
                    lane_res_next  = lane_reg;
                    value_res_next = VALUE_W'(rd_data);
                    last_next      = is_final && !cmd.done;
                    if (is_final)
                    begin
                        zip_done = 1'b1;
                        if (cmd.done)
                        begin
                            state_next = S_COMP;
                        end
                        else
                        begin
                            pop        = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        lane_next  = lane_reg + SRC_W'(1);
                        state_next = S_READ;
                    end
                end
            end
            S_COMP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    kind_res_next  = RES_COMPLETE;
                    lane_res_next  = '0;
                    value_res_next = '0;
                    last_next      = 1'b1;
                    pop            = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            lane_reg      <= '0;
            out_valid_reg <= 1'b0;
            kind_res_reg  <= '0;
            lane_res_reg  <= '0;
            value_res_reg <= '0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lane_reg      <= lane_next;
            out_valid_reg <= out_valid_next;
            kind_res_reg  <= kind_res_next;
            lane_res_reg  <= lane_res_next;
            value_res_reg <= value_res_next;
            last_reg      <= last_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign kind_res  = kind_res_reg;
    assign lane      = lane_res_reg;
    assign value_res = value_res_reg;
    assign last      = last_reg;

endmodule

>>> rtl/stream_zip_combiner.sv
// Path: a control result (error, completion, overflow) passes the command queue and the output
// register; the first zipped beat of a tuple also passes the pickup state and the store read.
// Throughput: one input beat per cycle until the command queue holds two commands. The back end
// takes one command at a time: a pickup, then a store read and an output step per tuple beat,
// and one more output step for a trailing completion. A value whose slot may be unread is held.
// Reset: rst_n async active low clears counts, pointers and flags, source count 4; store kept.
// ----------------------------------------------------------------------------
// stream_zip_combiner: element-wise zip of up to four tagged input streams
// Front end classifies beats and keeps per-source FIFOs in a shared store,
// a command queue decouples it from the back end that emits the results.
// ----------------------------------------------------------------------------
module stream_zip_combiner import szc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [KIND_W-1:0]  kind,
    input  logic [SRC_W-1:0]   source,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [KIND_W-1:0]  kind_res,
    output logic [SRC_W-1:0]   lane,
    output logic [VALUE_W-1:0] value_res,
    output logic               last,
    input  logic               cfg_wr_en,
    input  logic [CNT_W-1:0]   cfg_wr_data
);

    ram_wr_t               ram_wr;
    ram_rd_t               ram_rd;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  cmd_push;
    cmd_t                  cmd_in;
    cmd_t                  cmd_head;
    logic                  cmd_pop;
    q_status_t             q_status;
    logic                  zip_done;

    szc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .source      (source),
        .value       (value),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .ram_wr      (ram_wr),
        .cmd_push    (cmd_push),
        .cmd         (cmd_in),
        .q_status    (q_status),
        .zip_done    (zip_done)
    );

    szc_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .cmd_in   (cmd_in),
        .pop      (cmd_pop),
        .cmd_out  (cmd_head),
        .q_status (q_status)
    );

    szc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_SOURCES * QUEUE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (ram_rd.en),
        .rd_addr (ram_rd.addr),
        .rd_data (rd_data)
    );

    szc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_head),
        .q_status  (q_status),
        .pop       (cmd_pop),
        .ram_rd    (ram_rd),
        .rd_data   (rd_data),
        .zip_done  (zip_done),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .kind_res  (kind_res),
        .lane      (lane),
        .value_res (value_res),
        .last      (last)
    );

endmodule

>>> rtl/szc_checker.sv
// ----------------------------------------------------------------------------
// szc_checker: port-level checks of the stream zip combiner
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
module szc_checker import szc_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic [KIND_W-1:0]  kind_res,
    input logic [SRC_W-1:0]   lane,
    input logic [VALUE_W-1:0] value_res,
    input logic               last
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    // Keep a stalled payload stable
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            $stable(kind_res) && $stable(lane) && $stable(value_res) && $stable(last))
        else $error("stalled result payload changed");

    // Overflow and error beats stand alone
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind_res == RES_OVERFLOW || kind_res == RES_ERROR) |-> last)
        else $error("overflow or error beat without last");

    // Go quiet once completion or error is delivered
    a_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && (kind_res == RES_COMPLETE || kind_res == RES_ERROR)
        |=> !out_valid)
        else $error("result after completion or error");

endmodule

bind stream_zip_combiner szc_checker u_szc_checker (.*);
